// ===== rtl/quad_pid_motor_mixer_unit_macros.svh =====
// Assertion macros shared by the quad PID motor mixer RTL.
`ifndef QUAD_PID_MOTOR_MIXER_UNIT_MACROS_SVH
`define QUAD_PID_MOTOR_MIXER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define QPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define QPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/qpm_pkg.sv =====
// Shared widths, reset values, register codes and types of the quad PID motor mixer.
package qpm_pkg;

  localparam int ANGLE_W     = 16;
  localparam int ERR_W       = ANGLE_W + 1;
  localparam int DIFF_W      = ERR_W + 1;
  localparam int GAIN_W      = 24;
  localparam int LIMIT_W     = 12;
  localparam int THR_W       = 12;
  localparam int FLOOR_W     = 13;
  localparam int INTEG_W     = 32;
  localparam int FRAC_SHIFT  = 22;
  localparam int PID_W       = 13;
  localparam int PROD_W      = ERR_W + GAIN_W + 1;
  localparam int DPROD_W     = DIFF_W + GAIN_W + 1;
  localparam int PD_W        = DPROD_W + 1;
  localparam int SUM_W       = PD_W + 1;
  localparam int CLAMP_W     = LIMIT_W + FRAC_SHIFT + 1;
  localparam int MIX_W       = 18;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam int MOTOR_WIDTH_DEF = 13;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = 24'd39322;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST   = 24'd655;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST   = 24'd655360;
  localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RST = 12'd20;
  localparam logic [FLOOR_W-1:0] MOTOR_FLOOR_RST  = 13'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN,
    CFG_INTEG_GAIN,
    CFG_DERIV_GAIN,
    CFG_OUTPUT_LIMIT,
    CFG_TARGET_ROLL,
    CFG_TARGET_PITCH,
    CFG_TARGET_YAW,
    CFG_MOTOR_FLOOR
  } cfg_idx_t;

  // Per-stage load strobes: a stage register takes the item of the stage before it.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld5;
  } qpm_adv_t;

  // Controller settings shared by all three axis lanes.
  typedef struct packed {
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  ki;
    logic [GAIN_W-1:0]  kd;
    logic [LIMIT_W-1:0] limit;
  } qpm_gains_t;

endpackage

// ===== rtl/qpm_channels.sv =====
// Valid/ready channel interfaces for the attitude input and the motor result.
interface qpm_in_if import qpm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] roll_angle;
  logic signed [ANGLE_W-1:0] pitch_angle;
  logic signed [ANGLE_W-1:0] yaw_angle;
  logic        [THR_W-1:0]   throttle_level;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, throttle_level,
                  input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, throttle_level,
                  output ready);
endinterface

interface qpm_out_if import qpm_pkg::*; #(parameter int MOTOR_WIDTH = MOTOR_WIDTH_DEF) ();
  logic                   valid;
  logic                   ready;
  logic [MOTOR_WIDTH-1:0] motor_one;
  logic [MOTOR_WIDTH-1:0] motor_two;
  logic [MOTOR_WIDTH-1:0] motor_three;
  logic [MOTOR_WIDTH-1:0] motor_four;

  modport source (output valid, motor_one, motor_two, motor_three, motor_four,
                  input ready);
  modport sink   (input valid, motor_one, motor_two, motor_three, motor_four,
                  output ready);
endinterface

// ===== rtl/qpm_axis_lane.sv =====
// One axis PID lane: error, gain products, saturating integral, clamp and scaling.
module qpm_axis_lane import qpm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  qpm_adv_t                  adv,
  input  qpm_gains_t                gains,
  input  logic signed [ANGLE_W-1:0] angle,
  input  logic signed [ANGLE_W-1:0] target,
  output logic signed [PID_W-1:0]   pid
);

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  // Stage 1: error and error difference.
  logic signed [ERR_W-1:0]  err_nxt, err_r, last_err_r;
  logic signed [DIFF_W-1:0] diff_nxt, diff_r;
  // Stage 2: gain products.
  logic signed [PROD_W-1:0]  pp_nxt, pp_r, ip_nxt, ip_r;
  logic signed [DPROD_W-1:0] dp_nxt, dp_r;
  // Stage 3: running integral and proportional plus derivative.
  logic signed [PROD_W:0]    integ_sum;
  logic signed [INTEG_W-1:0] integ_nxt, integ_r;
  logic signed [PD_W-1:0]    pd_nxt, pd_r;
  // Stage 4: total and clamp.
  logic signed [SUM_W-1:0]   total, lim_pos, lim_neg, clamped;
  logic signed [CLAMP_W-1:0] sum_nxt, sum_r;
  // Stage 5: scaling toward zero.
  logic                      rnd;
  logic signed [CLAMP_W-1:0] quot;
  logic signed [PID_W-1:0]   pid_nxt, pid_r;

  assign err_nxt  = {angle[ANGLE_W-1], angle} - {target[ANGLE_W-1], target};
  assign diff_nxt = {err_nxt[ERR_W-1], err_nxt} - {last_err_r[ERR_W-1], last_err_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
    end else if (adv.ld1) begin
      last_err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.ld1) begin
      err_r  <= err_nxt;
      diff_r <= diff_nxt;
    end
  end

  assign pp_nxt = err_r * $signed({1'b0, gains.kp});
  assign ip_nxt = err_r * $signed({1'b0, gains.ki});
  assign dp_nxt = diff_r * $signed({1'b0, gains.kd});

  always_ff @(posedge clk) begin
    if (adv.ld2) begin
      pp_r <= pp_nxt;
      ip_r <= ip_nxt;
      dp_r <= dp_nxt;
    end
  end

  assign integ_sum = (PROD_W+1)'(integ_r) + (PROD_W+1)'(ip_r);

  always_comb begin
    if ((&integ_sum[PROD_W:INTEG_W-1]) || !(|integ_sum[PROD_W:INTEG_W-1])) begin
      integ_nxt = integ_sum[INTEG_W-1:0];
    end else if (integ_sum[PROD_W]) begin
      integ_nxt = INTEG_MIN;
    end else begin
      integ_nxt = INTEG_MAX;
    end
  end

  assign pd_nxt = PD_W'(pp_r) + PD_W'(dp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (adv.ld3) begin
      integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.ld3) begin
      pd_r <= pd_nxt;
    end
  end

  assign total   = SUM_W'(pd_r) + SUM_W'(integ_r);
  assign lim_pos = $signed(SUM_W'({gains.limit, {FRAC_SHIFT{1'b0}}}));
  assign lim_neg = -lim_pos;

  always_comb begin
    if (total > lim_pos) begin
      clamped = lim_pos;
    end else if (total < lim_neg) begin
      clamped = lim_neg;
    end else begin
      clamped = total;
    end
  end

  assign sum_nxt = clamped[CLAMP_W-1:0];

  always_ff @(posedge clk) begin
    if (adv.ld4) begin
      sum_r <= sum_nxt;
    end
  end

  // An arithmetic shift floors; a negative value with a nonzero fraction steps back up by one.
  assign rnd     = sum_r[CLAMP_W-1] && (|sum_r[FRAC_SHIFT-1:0]);
  assign quot    = (sum_r >>> FRAC_SHIFT) + $signed({{(CLAMP_W-1){1'b0}}, rnd});
  assign pid_nxt = quot[PID_W-1:0];

  always_ff @(posedge clk) begin
    if (adv.ld5) begin
      pid_r <= pid_nxt;
    end
  end

  assign pid = pid_r;

endmodule

// ===== rtl/qpm_mixer.sv =====
// Merge stage: mixes throttle and the three axis outputs into four limited motor commands.
module qpm_mixer import qpm_pkg::*; #(
  parameter int MOTOR_WIDTH = MOTOR_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   load,
  input  logic [THR_W-1:0]       throttle,
  input  logic signed [PID_W-1:0] roll_pid,
  input  logic signed [PID_W-1:0] pitch_pid,
  input  logic signed [PID_W-1:0] yaw_pid,
  input  logic [FLOOR_W-1:0]     floor_val,
  output logic [MOTOR_WIDTH-1:0] motor_one,
  output logic [MOTOR_WIDTH-1:0] motor_two,
  output logic [MOTOR_WIDTH-1:0] motor_three,
  output logic [MOTOR_WIDTH-1:0] motor_four
);

  localparam logic signed [MIX_W-1:0] MOTOR_TOP = $signed(MIX_W'({MOTOR_WIDTH{1'b1}}));

  logic signed [MIX_W-1:0] t_s, r_s, p_s, y_s, floor_s;
  logic signed [MIX_W-1:0] m1, m2, m3, m4;
  logic [MOTOR_WIDTH-1:0]  m1_r, m2_r, m3_r, m4_r;

  // Raise to the floor first, then saturate, so the motor maximum wins.
  function automatic logic [MOTOR_WIDTH-1:0] shape(input logic signed [MIX_W-1:0] mix,
                                                   input logic signed [MIX_W-1:0] flr);
    logic signed [MIX_W-1:0] v;
    v = (mix < flr) ? flr : mix;
    v = (v > MOTOR_TOP) ? MOTOR_TOP : v;
    return v[MOTOR_WIDTH-1:0];
  endfunction

  assign t_s     = $signed(MIX_W'(throttle));
  assign floor_s = $signed(MIX_W'(floor_val));
  assign r_s     = MIX_W'(roll_pid);
  assign p_s     = MIX_W'(pitch_pid);
  assign y_s     = MIX_W'(yaw_pid);

  assign m1 = t_s - r_s + p_s + y_s;
  assign m2 = t_s - r_s - p_s - y_s;
  assign m3 = t_s + r_s + p_s - y_s;
  assign m4 = t_s + r_s - p_s + y_s;

  always_ff @(posedge clk) begin
    if (load) begin
      m1_r <= shape(m1, floor_s);
      m2_r <= shape(m2, floor_s);
      m3_r <= shape(m3, floor_s);
      m4_r <= shape(m4, floor_s);
    end
  end

  assign motor_one   = m1_r;
  assign motor_two   = m2_r;
  assign motor_three = m3_r;
  assign motor_four  = m4_r;

endmodule

// ===== rtl/quad_pid_motor_mixer_unit.sv =====
// Throughput: one item per cycle, sustained while the output is not stalled; five pipeline
// stages per axis lane plus the registered mixer stage set the latency, and each stage
// holds one item.
// Reset (rst_n, synchronous, active low) restores the default gains, limit, setpoints and
// floor, clears each axis's previous error and running integral, and empties the pipeline.
`include "quad_pid_motor_mixer_unit_macros.svh"

module quad_pid_motor_mixer_unit import qpm_pkg::*; #(
  parameter int MOTOR_WIDTH = MOTOR_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  qpm_in_if.sink                in_ch,
  qpm_out_if.source             out_ch
);

  // Configuration registers. The user must change them only while the block is idle; the block
  // does not enforce this, and the pipeline reads them directly without a shadow copy.
  logic [GAIN_W-1:0]         prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [LIMIT_W-1:0]        output_limit_r;
  logic signed [ANGLE_W-1:0] target_roll_r, target_pitch_r, target_yaw_r;
  logic [FLOOR_W-1:0]        motor_floor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r    <= PROP_GAIN_RST;
      integ_gain_r   <= INTEG_GAIN_RST;
      deriv_gain_r   <= DERIV_GAIN_RST;
      output_limit_r <= OUTPUT_LIMIT_RST;
      target_roll_r  <= '0;
      target_pitch_r <= '0;
      target_yaw_r   <= '0;
      motor_floor_r  <= MOTOR_FLOOR_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PROP_GAIN:    prop_gain_r    <= cfg_data[GAIN_W-1:0];
        CFG_INTEG_GAIN:   integ_gain_r   <= cfg_data[GAIN_W-1:0];
        CFG_DERIV_GAIN:   deriv_gain_r   <= cfg_data[GAIN_W-1:0];
        CFG_OUTPUT_LIMIT: output_limit_r <= cfg_data[LIMIT_W-1:0];
        CFG_TARGET_ROLL:  target_roll_r  <= $signed(cfg_data[ANGLE_W-1:0]);
        CFG_TARGET_PITCH: target_pitch_r <= $signed(cfg_data[ANGLE_W-1:0]);
        CFG_TARGET_YAW:   target_yaw_r   <= $signed(cfg_data[ANGLE_W-1:0]);
        CFG_MOTOR_FLOOR:  motor_floor_r  <= cfg_data[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  qpm_gains_t gains;
  assign gains = '{kp: prop_gain_r, ki: integ_gain_r, kd: deriv_gain_r,
                   limit: output_limit_r};

  // Pipeline control. Each stage advances when the stage after it is empty or
  // advancing itself, so bubbles are squeezed out and the block keeps taking
  // transfers while a finished result waits in the output register.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, vo_r;
  logic en1, en2, en3, en4, en5, en_o;
  logic in_ready;
  qpm_adv_t adv;
  logic ld_o;

  always_comb begin
    en_o     = !vo_r || out_ch.ready;
    en5      = !v5_r || en_o;
    en4      = !v4_r || en5;
    en3      = !v3_r || en4;
    en2      = !v2_r || en3;
    en1      = !v1_r || en2;
    in_ready = rst_n && en1;
    adv.ld1  = in_ready && in_ch.valid;
    adv.ld2  = en2 && v1_r;
    adv.ld3  = en3 && v2_r;
    adv.ld4  = en4 && v3_r;
    adv.ld5  = en5 && v4_r;
    ld_o     = en_o && v5_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en1)  v1_r <= adv.ld1;
      if (en2)  v2_r <= v1_r;
      if (en3)  v3_r <= v2_r;
      if (en4)  v4_r <= v3_r;
      if (en5)  v5_r <= v4_r;
      if (en_o) vo_r <= v5_r;
    end
  end

  // The throttle travels beside the lanes until the mixer needs it.
  logic [THR_W-1:0] thr1_r, thr2_r, thr3_r, thr4_r, thr5_r;

  always_ff @(posedge clk) begin
    if (adv.ld1) thr1_r <= in_ch.throttle_level;
    if (adv.ld2) thr2_r <= thr1_r;
    if (adv.ld3) thr3_r <= thr2_r;
    if (adv.ld4) thr4_r <= thr3_r;
    if (adv.ld5) thr5_r <= thr4_r;
  end

  // Three identical lanes, one per axis, each keeping its own previous error
  // and running integral.
  logic signed [PID_W-1:0] roll_pid, pitch_pid, yaw_pid;

  qpm_axis_lane u_roll (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .gains  (gains),
    .angle  (in_ch.roll_angle),
    .target (target_roll_r),
    .pid    (roll_pid)
  );

  qpm_axis_lane u_pitch (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .gains  (gains),
    .angle  (in_ch.pitch_angle),
    .target (target_pitch_r),
    .pid    (pitch_pid)
  );

  qpm_axis_lane u_yaw (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .gains  (gains),
    .angle  (in_ch.yaw_angle),
    .target (target_yaw_r),
    .pid    (yaw_pid)
  );

  // The mixer combines the lane outputs and holds the result until it is taken.
  logic [MOTOR_WIDTH-1:0] motor_one, motor_two, motor_three, motor_four;

  qpm_mixer #(.MOTOR_WIDTH(MOTOR_WIDTH)) u_mixer (
    .clk         (clk),
    .load        (ld_o),
    .throttle    (thr5_r),
    .roll_pid    (roll_pid),
    .pitch_pid   (pitch_pid),
    .yaw_pid     (yaw_pid),
    .floor_val   (motor_floor_r),
    .motor_one   (motor_one),
    .motor_two   (motor_two),
    .motor_three (motor_three),
    .motor_four  (motor_four)
  );

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = vo_r;
  assign out_ch.motor_one   = motor_one;
  assign out_ch.motor_two   = motor_two;
  assign out_ch.motor_three = motor_three;
  assign out_ch.motor_four  = motor_four;

  // An accepted transfer always lands in the first stage.
  `QPM_ASSERT_NEXT(a_accept_fills_s1, in_ch.valid && in_ch.ready, v1_r, "accepted item lost")
  // Input back-pressure only appears when every stage holds an item.
  `QPM_ASSERT_NOW(a_ready_low_full, !in_ch.ready, v1_r && v2_r && v3_r && v4_r && v5_r && vo_r, "input stalled with a free stage")
  // A new result only appears when the last lane stage held an item.
  `QPM_ASSERT_NOW(a_result_from_s5, $rose(out_ch.valid), $past(v5_r), "result without a source item")

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the quad PID motor mixer: predicted motor commands vs. DUT.
`timescale 1ns / 1ps

module testbench;
  import qpm_pkg::*;

  // With the stalls of both sides bounded, a correct block never goes this long
  // without a transfer or a register write.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 8;
  localparam int ITEMS_PER_PHASE = 106;
  localparam int MAX_IDLE       = 16;
  // The tail wait leaves some margin after the last checked result.
  localparam int TAIL_CYCLES    = 10;

  // One attitude sample with its throttle, as it crosses the input channel.
  typedef struct packed {
    logic signed [ANGLE_W-1:0] roll;
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] yaw;
    logic [THR_W-1:0]          throttle;
  } attitude_t;

  // The four motor commands of one result transfer.
  typedef struct packed {
    logic [MOTOR_WIDTH_DEF-1:0] one;
    logic [MOTOR_WIDTH_DEF-1:0] two;
    logic [MOTOR_WIDTH_DEF-1:0] three;
    logic [MOTOR_WIDTH_DEF-1:0] four;
  } motor_set_t;

  // Full register set of the controller.
  typedef struct packed {
    logic [GAIN_W-1:0]         kp;
    logic [GAIN_W-1:0]         ki;
    logic [GAIN_W-1:0]         kd;
    logic [LIMIT_W-1:0]        limit;
    logic signed [ANGLE_W-1:0] target_roll;
    logic signed [ANGLE_W-1:0] target_pitch;
    logic signed [ANGLE_W-1:0] target_yaw;
    logic [FLOOR_W-1:0]        motor_floor;
  } ctrl_set_t;

  localparam ctrl_set_t RESET_SETTINGS = '{
    kp: PROP_GAIN_RST, ki: INTEG_GAIN_RST, kd: DERIV_GAIN_RST, limit: OUTPUT_LIMIT_RST,
    target_roll: '0, target_pitch: '0, target_yaw: '0, motor_floor: MOTOR_FLOOR_RST
  };

  // Attitude controller and mixer predictor, together with the queue of motor commands
  // still owed by the DUT.
  class mixer_model;
    localparam longint ACC_MAX = 64'sd2147483647;
    localparam longint ACC_MIN = -ACC_MAX - 64'sd1;
    localparam longint UNIT    = 64'sd1 <<< FRAC_SHIFT;
    localparam longint TOP     = (64'sd1 <<< MOTOR_WIDTH_DEF) - 64'sd1;

    ctrl_set_t  regs;
    longint     prev_err[3];
    longint     integ_acc[3];
    motor_set_t expected_motors[$];
    int         failures;

    function new();
      regs = RESET_SETTINGS;
      for (int i = 0; i < 3; i++) begin
        prev_err[i]  = 0;
        integ_acc[i] = 0;
      end
      failures = 0;
    endfunction

    function void load(ctrl_set_t s);
      regs = s;
    endfunction

    // One axis: P on the error, saturating integral, D on the error change, then the
    // symmetric clamp and truncation toward zero into motor units.
    function longint axis_term(int axis, longint angle, longint target);
      longint err, diff, acc, lim, total;
      err  = angle - target;
      diff = err - prev_err[axis];
      acc  = integ_acc[axis] + err * longint'(regs.ki);
      if (acc > ACC_MAX) acc = ACC_MAX;
      if (acc < ACC_MIN) acc = ACC_MIN;
      integ_acc[axis] = acc;
      prev_err[axis]  = err;
      total = err * longint'(regs.kp) + acc + diff * longint'(regs.kd);
      lim = longint'(regs.limit) * UNIT;
      if (total > lim) total = lim;
      if (total < -lim) total = -lim;
      return total / UNIT;
    endfunction

    // The floor goes on first, so a saturation at the top always wins.
    function logic [MOTOR_WIDTH_DEF-1:0] motor_cmd(longint mix);
      if (mix < longint'(regs.motor_floor)) mix = longint'(regs.motor_floor);
      if (mix > TOP) mix = TOP;
      return MOTOR_WIDTH_DEF'(mix);
    endfunction

    function void accept_attitude(attitude_t a);
      longint r, p, y, t;
      motor_set_t m;
      r = axis_term(0, longint'($signed(a.roll)), longint'($signed(regs.target_roll)));
      p = axis_term(1, longint'($signed(a.pitch)), longint'($signed(regs.target_pitch)));
      y = axis_term(2, longint'($signed(a.yaw)), longint'($signed(regs.target_yaw)));
      t = longint'(a.throttle);
      m.one   = motor_cmd(t - r + p + y);
      m.two   = motor_cmd(t - r - p - y);
      m.three = motor_cmd(t + r + p - y);
      m.four  = motor_cmd(t + r - p + y);
      expected_motors.push_back(m);
    endfunction

    function void compare_motor(string name, logic [MOTOR_WIDTH_DEF-1:0] want,
                                logic [MOTOR_WIDTH_DEF-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_motors(motor_set_t got);
      motor_set_t want;
      if (expected_motors.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0d %0d %0d %0d", $time,
                 got.one, got.two, got.three, got.four);
        failures++;
        return;
      end
      want = expected_motors.pop_front();
      compare_motor("motor_one", want.one, got.one);
      compare_motor("motor_two", want.two, got.two);
      compare_motor("motor_three", want.three, got.three);
      compare_motor("motor_four", want.four, got.four);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  qpm_in_if  in_bus ();
  qpm_out_if out_bus ();

  quad_pid_motor_mixer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_bus),
    .out_ch    (out_bus)
  );

  mixer_model board = new();

  // When set, neither side idles: back-to-back transfers for a whole phase.
  bit no_idle = 1'b0;
  int quiet_cycles = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic attitude_t make_attitude(int r, int p, int y, int t);
    attitude_t a;
    a.roll     = ANGLE_W'(r);
    a.pitch    = ANGLE_W'(p);
    a.yaw      = ANGLE_W'(y);
    a.throttle = THR_W'(t);
    return a;
  endfunction

  // Register contents as written on the port. The bits above a narrow register are
  // filled with noise, which the block must drop.
  function automatic logic [CFG_DATA_W-1:0] reg_word(ctrl_set_t s, cfg_idx_t idx);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'($urandom);
    case (idx)
      CFG_PROP_GAIN:    return s.kp;
      CFG_INTEG_GAIN:   return s.ki;
      CFG_DERIV_GAIN:   return s.kd;
      CFG_OUTPUT_LIMIT: return {noise[CFG_DATA_W-1:LIMIT_W], s.limit};
      CFG_TARGET_ROLL:  return {noise[CFG_DATA_W-1:ANGLE_W], s.target_roll};
      CFG_TARGET_PITCH: return {noise[CFG_DATA_W-1:ANGLE_W], s.target_pitch};
      CFG_TARGET_YAW:   return {noise[CFG_DATA_W-1:ANGLE_W], s.target_yaw};
      default:          return {noise[CFG_DATA_W-1:FLOOR_W], s.motor_floor};
    endcase
  endfunction

  // Writes all eight registers on consecutive edges. The write enable stays high across
  // the burst and drops once at the end. Only called while the block is idle.
  task automatic apply_settings(input ctrl_set_t s);
    cfg_we <= 1'b1;
    for (int i = 0; i <= int'(CFG_MOTOR_FLOOR); i++) begin
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= reg_word(s, cfg_idx_t'(i));
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    board.load(s);
  endtask

  // Presents one sample after a random gap and returns at the edge of its transfer.
  // With no gap, valid simply stays high from the previous transfer.
  task automatic send_attitude(input attitude_t a);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.roll_angle     <= a.roll;
    in_bus.pitch_angle    <= a.pitch;
    in_bus.yaw_angle      <= a.yaw;
    in_bus.throttle_level <= a.throttle;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
    board.accept_attitude(a);
  endtask

  // Stops the input and waits until every predicted result has been checked.
  task automatic wait_for_results();
    in_bus.valid <= 1'b0;
    while (board.expected_motors.size() != 0) @(posedge clk);
  endtask

  function automatic logic [GAIN_W-1:0] draw_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(0, 'h3FFFF));
    endcase
  endfunction

  function automatic logic signed [ANGLE_W-1:0] draw_target();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 16'sh7FFF;
      2:       return 16'sh8000;
      default: return ANGLE_W'($urandom);
    endcase
  endfunction

  // Mostly moderate settings, so the mixer output moves around instead of pinning at
  // a rail; the extremes turn up now and then.
  function automatic ctrl_set_t draw_settings();
    ctrl_set_t s;
    s.kp = draw_gain();
    s.ki = draw_gain();
    s.kd = draw_gain();
    s.limit = ($urandom_range(0, 4) == 0) ? LIMIT_W'($urandom_range(0, 4095))
                                          : LIMIT_W'($urandom_range(0, 300));
    s.target_roll  = draw_target();
    s.target_pitch = draw_target();
    s.target_yaw   = draw_target();
    s.motor_floor = ($urandom_range(0, 4) == 0) ? FLOOR_W'($urandom_range(0, 8191))
                                                : FLOOR_W'($urandom_range(0, 1500));
    return s;
  endfunction

  // Angles mostly hover around the setpoint, the way a flying craft does, so the
  // integral and derivative terms stay out of saturation; the rest are full-range.
  function automatic logic signed [ANGLE_W-1:0] draw_angle(logic signed [ANGLE_W-1:0] target);
    int spread;
    int offset;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        spread = $urandom_range(0, 2048);
        offset = int'($urandom_range(0, 2 * spread)) - spread;
        return ANGLE_W'(int'(target) + offset);
      end
      6, 7, 8: return ANGLE_W'($urandom);
      default: return ($urandom_range(0, 1) == 0) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  function automatic attitude_t draw_attitude();
    attitude_t a;
    a.roll  = draw_angle(board.regs.target_roll);
    a.pitch = draw_angle(board.regs.target_pitch);
    a.yaw   = draw_angle(board.regs.target_yaw);
    case ($urandom_range(0, 9))
      0:       a.throttle = '0;
      1:       a.throttle = '1;
      default: a.throttle = THR_W'($urandom_range(0, 4095));
    endcase
    return a;
  endfunction

  // Result side: a random stall before each transfer, none in the no-idle phases.
  // Ready stays high between back-to-back transfers.
  initial begin
    int stall;
    motor_set_t got;
    out_bus.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid && out_bus.ready));
      got.one   = out_bus.motor_one;
      got.two   = out_bus.motor_two;
      got.three = out_bus.motor_three;
      got.four  = out_bus.motor_four;
      board.check_motors(got);
    end
  end

  // Watchdog: a long run of cycles with no transfer and no register write means the
  // block has hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || cfg_we) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    ctrl_set_t s;
    cfg_we                <= 1'b0;
    cfg_index             <= '0;
    cfg_data              <= '0;
    in_bus.valid          <= 1'b0;
    in_bus.roll_angle     <= '0;
    in_bus.pitch_angle    <= '0;
    in_bus.yaw_angle      <= '0;
    in_bus.throttle_level <= '0;
    rst_n                 <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings. A level craft at zero throttle drives every motor down to the
    // floor; the full-scale angles make negative mixes, which are also raised to the
    // floor. A repeated sample checks that the derivative term drops out.
    send_attitude(make_attitude(0, 0, 0, 0));
    send_attitude(make_attitude(32767, 0, 0, 4095));
    send_attitude(make_attitude(-32768, 32767, -32768, 0));
    send_attitude(make_attitude(32767, 32767, 32767, 4095));
    send_attitude(make_attitude(-32768, -32768, -32768, 2048));
    send_attitude(make_attitude(64, -64, 128, 1500));
    send_attitude(make_attitude(64, -64, 128, 1500));
    wait_for_results();

    // Full gains with the setpoints at opposite rails: the error reaches its widest
    // value and the running integral saturates first one way, then the other. A zero
    // floor lets the outputs touch both 0 and the top code.
    s = '{kp: '1, ki: '1, kd: '1, limit: '1, target_roll: 16'sh8000,
          target_pitch: 16'sh7FFF, target_yaw: '0, motor_floor: '0};
    apply_settings(s);
    send_attitude(make_attitude(32767, -32768, 32767, 4095));
    send_attitude(make_attitude(32767, -32768, -32768, 0));
    send_attitude(make_attitude(32767, -32768, 0, 2000));
    send_attitude(make_attitude(-32768, 32767, 0, 2000));
    send_attitude(make_attitude(-32768, 32767, -32768, 4095));
    send_attitude(make_attitude(-32768, 32767, 32767, 0));
    wait_for_results();

    // A zero limit forces every axis term to zero whatever the gain; a floor at the
    // top code pins every motor there.
    s = '{kp: '0, ki: '1, kd: '0, limit: '0, target_roll: '0,
          target_pitch: '0, target_yaw: '0, motor_floor: '1};
    apply_settings(s);
    send_attitude(make_attitude(32767, -32768, 1000, 0));
    send_attitude(make_attitude(-32768, 32767, -1000, 4095));
    send_attitude(make_attitude(12345, -2222, 777, 1234));
    wait_for_results();

    // All gains at zero: the motors just follow the throttle above a zero floor.
    s = '{kp: '0, ki: '0, kd: '0, limit: '1, target_roll: 16'sh7FFF,
          target_pitch: 16'sh8000, target_yaw: 16'sh7FFF, motor_floor: '0};
    apply_settings(s);
    send_attitude(make_attitude(0, 0, 0, 4095));
    send_attitude(make_attitude(-32768, 32767, -32768, 1));
    send_attitude(make_attitude(32767, -32768, 32767, 0));
    wait_for_results();

    // Random phases: new settings each time, with the axis state carried across.
    // About one phase in four runs with no idling on either side.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      apply_settings(draw_settings());
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_attitude(draw_attitude());
      end
      wait_for_results();
      no_idle = 1'b0;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
